// ----- hw/rtl/kat_pkg.sv -----
// ----------------------------------------------------------------------------
// kat_pkg: shared types and constants of the keepalive aging table
// table size, field widths, reset values, operation and event codes, register indexes
// ----------------------------------------------------------------------------
package kat_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned IP_W       = 32;
  localparam int unsigned AGE_W      = 22;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned TIMEOUT_W  = 20;
  localparam int unsigned CFG_W      = 20;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 20'd10000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_TICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    EV_ADDED    = 3'd0,
    EV_DELETED  = 3'd1,
    EV_EXPIRED  = 3'd2,
    EV_LISTED   = 3'd3,
    EV_REJECTED = 3'd4
  } event_kind_e;

endpackage

// ----- hw/rtl/keepalive_aging_table.sv -----
// ----------------------------------------------------------------------------
// keepalive_aging_table: client address table with per-entry age
// entries are kept packed in slots 0..count-1 sorted by ascending address,
// so every scan reports in address order with one shared compare path
// ----------------------------------------------------------------------------
//
//  port group   direction  handshake                   payload
//  command      in         start & !busy               opcode_i, client_ip_i
//  event        out        event_valid_o, no stall     event_kind_o, event_ip_o,
//                                                      last_event_o
//  config       in         cfg_we_i, no wait           cfg_index_i, cfg_wdata_i
//
//  steps: tick and clear pass over the entries, one slot per cycle; add does a
//  forward search, then a backward shift to open a slot; delete does a search,
//  then forward compaction; all of them share the single slot read/compare/write
//  path; each event word is registered and shown for exactly one cycle; reports
//  of tick, clear and delete are held back so the final one can be marked last
//  reset: table empty, registers at 1000 and 10000; no clearing pass needed
//  the receiver cannot stall; busy is high from the cycle after start and
//  drops in the cycle the last event word is shown
// ----------------------------------------------------------------------------
module keepalive_aging_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode_i,
  input  logic [kat_pkg::IP_W-1:0]     client_ip_i,
  input  logic                         cfg_we_i,
  input  logic [kat_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [kat_pkg::CFG_W-1:0]    cfg_wdata_i,
  output logic                         event_valid_o,
  output logic [2:0]                   event_kind_o,
  output logic [kat_pkg::IP_W-1:0]     event_ip_o,
  output logic                         last_event_o
);
  import kat_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,   // forward scan for match or insertion point
    ST_SHIFT,    // backward move to open the insertion slot
    ST_COMPACT   // forward pass: age, drop, pack and report
  } state_e;

  // table storage, packed and sorted, count holds the fill level
  logic [IP_W-1:0]  slot_addr_q [TABLE_DEPTH];
  logic [AGE_W-1:0] slot_age_q  [TABLE_DEPTH];

  state_e             state_q, state_d;
  opcode_e            op_q, op_d;
  logic [IP_W-1:0]    ip_q, ip_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   rd_q, rd_d;      // read pointer
  logic [CNT_W-1:0]   wr_q, wr_d;      // write pointer while compacting
  logic [CNT_W-1:0]   pos_q, pos_d;    // insertion point

  // one held report so the final one can be marked last
  logic               hold_v_q, hold_v_d;
  event_kind_e        hold_kind_q, hold_kind_d;
  logic [IP_W-1:0]    hold_ip_q, hold_ip_d;

  logic [INTERVAL_W-1:0] interval_q;
  logic [TIMEOUT_W-1:0]  timeout_q;

  // registered event word
  logic               ev_valid_q, ev_valid_d;
  event_kind_e        ev_kind_q, ev_kind_d;
  logic [IP_W-1:0]    ev_ip_q, ev_ip_d;
  logic               ev_last_q, ev_last_d;

  // table write port
  logic               tw_en;
  logic [IDX_W-1:0]   tw_idx;
  logic [IP_W-1:0]    tw_addr;
  logic [AGE_W-1:0]   tw_age;

  // shared read port and arithmetic
  logic [CNT_W-1:0]   rd_m1;
  logic [IP_W-1:0]    rd_addr;
  logic [AGE_W-1:0]   rd_age;
  logic [IP_W-1:0]    prev_addr;
  logic [AGE_W-1:0]   prev_age;
  logic [AGE_W:0]     aged;
  logic               expired;
  logic [AGE_W-1:0]   fresh_age;
  logic               accept;

  assign accept    = start && !busy;
  assign rd_m1     = rd_q - CNT_W'(1);
  assign rd_addr   = slot_addr_q[rd_q[IDX_W-1:0]];
  assign rd_age    = slot_age_q[rd_q[IDX_W-1:0]];
  assign prev_addr = slot_addr_q[rd_m1[IDX_W-1:0]];
  assign prev_age  = slot_age_q[rd_m1[IDX_W-1:0]];

  // age plus interval one bit wider, signed compare against the timeout
  assign aged      = {rd_age[AGE_W-1], rd_age} + (AGE_W+1)'(interval_q);
  assign expired   = $signed(aged) > $signed({3'b000, timeout_q});
  assign fresh_age = ~AGE_W'(interval_q) + AGE_W'(1);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ip_d        = ip_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    pos_d       = pos_q;
    hold_v_d    = hold_v_q;
    hold_kind_d = hold_kind_q;
    hold_ip_d   = hold_ip_q;
    ev_valid_d  = 1'b0;
    ev_kind_d   = ev_kind_q;
    ev_ip_d     = ev_ip_q;
    ev_last_d   = ev_last_q;
    tw_en       = 1'b0;
    tw_idx      = rd_q[IDX_W-1:0];
    tw_addr     = rd_addr;
    tw_age      = rd_age;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d     = opcode_e'(opcode_i);
          ip_d     = client_ip_i;
          rd_d     = '0;
          wr_d     = '0;
          hold_v_d = 1'b0;
          unique case (opcode_e'(opcode_i))
            OP_ADD, OP_DELETE: state_d = ST_SEARCH;
            OP_TICK, OP_CLEAR: state_d = ST_COMPACT;
            default:           state_d = ST_IDLE;
          endcase
        end
      end

      ST_SEARCH: begin
        if (rd_q != cnt_q && rd_addr == ip_q) begin
          if (op_q == OP_ADD) begin
            // refresh: age back to fresh, no report
            tw_en   = 1'b1;
            tw_age  = fresh_age;
            state_d = ST_IDLE;
          end else begin
            // delete: report held until the tail is packed down
            hold_v_d    = 1'b1;
            hold_kind_d = EV_DELETED;
            hold_ip_d   = ip_q;
            wr_d        = rd_q;
            rd_d        = rd_q + CNT_W'(1);
            state_d     = ST_COMPACT;
          end
        end else if (rd_q == cnt_q || rd_addr > ip_q) begin
          // absent; insertion point is here
          if (op_q == OP_DELETE) begin
            state_d = ST_IDLE;
          end else if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
            ev_valid_d = 1'b1;
            ev_kind_d  = EV_REJECTED;
            ev_ip_d    = ip_q;
            ev_last_d  = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            pos_d   = rd_q;
            rd_d    = cnt_q;
            state_d = ST_SHIFT;
          end
        end else begin
          rd_d = rd_q + CNT_W'(1);
        end
      end

      ST_SHIFT: begin
        tw_en = 1'b1;
        if (rd_q != pos_q) begin
          tw_addr = prev_addr;
          tw_age  = prev_age;
          rd_d    = rd_m1;
        end else begin
          tw_addr    = ip_q;
          tw_age     = fresh_age;
          cnt_d      = cnt_q + CNT_W'(1);
          ev_valid_d = 1'b1;
          ev_kind_d  = EV_ADDED;
          ev_ip_d    = ip_q;
          ev_last_d  = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      ST_COMPACT: begin
        if (rd_q == cnt_q) begin
          cnt_d = wr_q;
          if (hold_v_q) begin
            ev_valid_d = 1'b1;
            ev_kind_d  = hold_kind_q;
            ev_ip_d    = hold_ip_q;
            ev_last_d  = 1'b1;
          end
          hold_v_d = 1'b0;
          state_d  = ST_IDLE;
        end else begin
          rd_d = rd_q + CNT_W'(1);
          if ((op_q == OP_TICK && expired) || op_q == OP_CLEAR) begin
            // drop this entry; flush the previous report, hold this one
            if (hold_v_q) begin
              ev_valid_d = 1'b1;
              ev_kind_d  = hold_kind_q;
              ev_ip_d    = hold_ip_q;
              ev_last_d  = 1'b0;
            end
            hold_v_d    = 1'b1;
            hold_kind_d = (op_q == OP_CLEAR) ? EV_LISTED : EV_EXPIRED;
            hold_ip_d   = rd_addr;
          end else begin
            tw_en  = 1'b1;
            tw_idx = wr_q[IDX_W-1:0];
            tw_age = (op_q == OP_TICK) ? aged[AGE_W-1:0] : rd_age;
            wr_d   = wr_q + CNT_W'(1);
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state, config registers and event valid and last flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= OP_ADD;
      cnt_q      <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      pos_q      <= '0;
      hold_v_q   <= 1'b0;
      ev_valid_q <= 1'b0;
      ev_last_q  <= 1'b0;
      interval_q <= INTERVAL_RESET;
      timeout_q  <= TIMEOUT_RESET;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      cnt_q      <= cnt_d;
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      pos_q      <= pos_d;
      hold_v_q   <= hold_v_d;
      ev_valid_q <= ev_valid_d;
      ev_last_q  <= ev_last_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_TICK_INTERVAL: interval_q <= cfg_wdata_i[INTERVAL_W-1:0];
          REG_TIMEOUT:       timeout_q  <= cfg_wdata_i[TIMEOUT_W-1:0];
          default:           ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    ip_q        <= ip_d;
    hold_kind_q <= hold_kind_d;
    hold_ip_q   <= hold_ip_d;
    ev_kind_q   <= ev_kind_d;
    ev_ip_q     <= ev_ip_d;
  end

  // single write port into the table
  always_ff @(posedge clk_i) begin
    if (tw_en) begin
      slot_addr_q[tw_idx] <= tw_addr;
      slot_age_q[tw_idx]  <= tw_age;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign event_valid_o = ev_valid_q;
  assign event_kind_o  = ev_kind_q;
  assign event_ip_o    = ev_ip_q;
  assign last_event_o  = ev_last_q;

  // fill level never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("table count out of range");

  // single-report operations always mark their word last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_valid_o && (event_kind_o == EV_ADDED || event_kind_o == EV_DELETED ||
                       event_kind_o == EV_REJECTED)) |-> last_event_o)
    else $error("single report not marked last");

  // every accepted command makes the sequencer busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command accepted without going busy");

  // packing never writes ahead of the read pointer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMPACT) |-> (wr_q <= rd_q))
    else $error("compaction write pointer ahead of read pointer");

  // the last word of a command comes out after the sequencer is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_valid_o && last_event_o) |-> !busy)
    else $error("last event word while still busy");

endmodule

// ----- verif/keepalive_event_checker.sv -----
// ----------------------------------------------------------------------------
// keepalive_event_checker: event stream checker for the keepalive aging table
// keeps its own copy of the address table and the timing registers, works out
// the event words of every accepted command and compares each event word
// ----------------------------------------------------------------------------
module keepalive_event_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [1:0]                     opcode_i,
  input  logic [kat_pkg::IP_W-1:0]       client_ip_i,
  input  logic                           cfg_we_i,
  input  logic [kat_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kat_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           event_valid_i,
  input  logic [2:0]                     event_kind_i,
  input  logic [kat_pkg::IP_W-1:0]       event_ip_i,
  input  logic                           last_event_i,
  output int                             error_count_o,
  output int                             pending_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import kat_pkg::*;

  typedef struct packed {
    event_kind_e     kind;
    logic [IP_W-1:0] ip;
    logic            last;
  } event_word_t;

  logic                   entry_used [TABLE_DEPTH];
  logic [IP_W-1:0]        entry_ip   [TABLE_DEPTH];
  logic signed [AGE_W-1:0] entry_age [TABLE_DEPTH];
  logic [INTERVAL_W-1:0]  tick_step;
  logic [TIMEOUT_W-1:0]   age_limit;

  event_word_t     expected_events [$];
  logic [IP_W-1:0] swept_ips [$];
  event_word_t     oldest;

  task automatic report_mismatch(input string what);
    $display("%0t ns: event mismatch: %s", $time, what);
    error_count_o++;
  endtask

  task automatic empty_table();
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      entry_used[s] = 1'b0;
      entry_ip[s]   = '0;
      entry_age[s]  = '0;
    end
    tick_step = INTERVAL_RESET;
    age_limit = TIMEOUT_RESET;
    expected_events.delete();
    swept_ips.delete();
  endtask

  function automatic int slot_of(input logic [IP_W-1:0] ip);
    for (int s = 0; s < TABLE_DEPTH; s++)
      if (entry_used[s] && entry_ip[s] == ip) return s;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int s = 0; s < TABLE_DEPTH; s++)
      if (!entry_used[s]) return s;
    return -1;
  endfunction

  task automatic push_event(input event_kind_e kind, input logic [IP_W-1:0] ip,
                            input logic last);
    event_word_t w;
    w.kind = kind;
    w.ip   = ip;
    w.last = last;
    expected_events = {expected_events, w};
  endtask

  // swept addresses go out in ascending order, last flag on the final one
  task automatic announce_swept(input event_kind_e kind);
    logic [IP_W-1:0] ordered [$];
    int pos;
    foreach (swept_ips[n]) begin
      pos = 0;
      while (pos < ordered.size() && ordered[pos] < swept_ips[n]) pos++;
      ordered.insert(pos, swept_ips[n]);
    end
    foreach (ordered[n]) push_event(kind, ordered[n], n == ordered.size() - 1);
    swept_ips.delete();
  endtask

  task automatic predict_command(input opcode_e op, input logic [IP_W-1:0] ip);
    int s;
    logic signed [AGE_W-1:0] fresh_age;
    logic signed [AGE_W-1:0] limit;
    fresh_age = -$signed({6'd0, tick_step});
    limit     = $signed({2'd0, age_limit});
    s         = slot_of(ip);
    case (op)
      OP_ADD: begin
        if (s >= 0) begin
          entry_age[s] = fresh_age;
        end else begin
          s = free_slot();
          if (s < 0) begin
            push_event(EV_REJECTED, ip, 1'b1);
          end else begin
            entry_used[s] = 1'b1;
            entry_ip[s]   = ip;
            entry_age[s]  = fresh_age;
            push_event(EV_ADDED, ip, 1'b1);
          end
        end
      end
      OP_DELETE: begin
        if (s >= 0) begin
          entry_used[s] = 1'b0;
          push_event(EV_DELETED, ip, 1'b1);
        end
      end
      OP_TICK: begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (entry_used[k]) begin
            entry_age[k] = entry_age[k] + $signed({6'd0, tick_step});
            if (entry_age[k] > limit) begin
              entry_used[k] = 1'b0;
              swept_ips = {swept_ips, entry_ip[k]};
            end
          end
        end
        announce_swept(EV_EXPIRED);
      end
      default: begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (entry_used[k]) begin
            entry_used[k] = 1'b0;
            swept_ips = {swept_ips, entry_ip[k]};
          end
        end
        announce_swept(EV_LISTED);
      end
    endcase
  endtask

  // all values read here are the ones before the edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      empty_table();
    end else begin
      if (event_valid_i) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d ip %h last %b",
                                    event_kind_i, event_ip_i, last_event_i));
        end else begin
          oldest = expected_events.pop_front();
          if (event_kind_i !== oldest.kind)
            report_mismatch($sformatf("kind %0d, expected %0d (ip %h)",
                                      event_kind_i, oldest.kind, oldest.ip));
          if (event_ip_i !== oldest.ip)
            report_mismatch($sformatf("ip %h, expected %h", event_ip_i, oldest.ip));
          if (last_event_i !== oldest.last)
            report_mismatch($sformatf("last %b, expected %b (ip %h)",
                                      last_event_i, oldest.last, oldest.ip));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TICK_INTERVAL: tick_step = cfg_wdata_i[INTERVAL_W-1:0];
          REG_TIMEOUT:       age_limit = cfg_wdata_i[TIMEOUT_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) predict_command(opcode_e'(opcode_i), client_ip_i);
    end
    pending_count_o = expected_events.size();
  end

endmodule

// ----- verif/keepalive_aging_table_test.sv -----
// ----------------------------------------------------------------------------
// keepalive_aging_table_test: command-level test of the keepalive aging table
// directed corner commands, then phases of random command streams under
// several timing register settings; an event checker predicts and compares
// ----------------------------------------------------------------------------
module keepalive_aging_table_test;

  timeunit 1ns;
  timeprecision 1ps;

  import kat_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_WAIT  = 40;    // longer than a full-table add or scan
  localparam int POOL_SIZE    = 40;    // more addresses than slots, so adds can fill

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  opcode_e              command_op = OP_ADD;
  logic [IP_W-1:0]      command_ip = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TICK_INTERVAL;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 event_valid;
  logic [2:0]           event_kind;
  logic [IP_W-1:0]      event_ip;
  logic                 last_event;

  int error_count;
  int pending_count;
  int cycle_count = 0;

  bit              sender_pauses = 1'b1;
  logic [IP_W-1:0] client_pool [POOL_SIZE];

  keepalive_aging_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (command_op),
    .client_ip_i   (command_ip),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .event_valid_o (event_valid),
    .event_kind_o  (event_kind),
    .event_ip_o    (event_ip),
    .last_event_o  (last_event)
  );

  keepalive_event_checker event_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .opcode_i        (command_op),
    .client_ip_i     (command_ip),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .event_valid_i   (event_valid),
    .event_kind_i    (event_kind),
    .event_ip_i      (event_ip),
    .last_event_i    (last_event),
    .error_count_o   (error_count),
    .pending_count_o (pending_count)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop in case the block hangs or drops words
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one command word; wait for the block to go idle, maybe pause for random idle
  // cycles, then hold start high up to the accepting edge
  task automatic send_command(input opcode_e op, input logic [IP_W-1:0] ip);
    @(negedge clk_i);
    start = 1'b0;
    while (busy) @(negedge clk_i);
    while (sender_pauses && $urandom_range(0, 99) < 18) @(negedge clk_i);
    start      = 1'b1;
    command_op = op;
    command_ip = ip;
    // busy read right after the edge is the value the block saw at that edge
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // registers only change with nothing in flight: all expected words in,
  // then enough cycles for a command that makes no word to finish its scan
  task automatic wait_quiet();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_WAIT) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic program_timing(input logic [INTERVAL_W-1:0] interval,
                                input logic [TIMEOUT_W-1:0] timeout);
    logic [CFG_W-INTERVAL_W-1:0] spare_bits;
    spare_bits = (CFG_W-INTERVAL_W)'($urandom);    // bits above the interval field are dropped
    wait_quiet();
    cfg_we    = 1'b1;
    cfg_index = REG_TICK_INTERVAL;
    cfg_wdata = {spare_bits, interval};
    @(negedge clk_i);
    cfg_index = REG_TIMEOUT;
    cfg_wdata = timeout;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  // fresh address set per phase, both extremes always in it
  task automatic refill_pool();
    foreach (client_pool[k]) client_pool[k] = $urandom;
    client_pool[0] = '0;
    client_pool[1] = '1;
  endtask

  function automatic logic [IP_W-1:0] pick_client();
    if ($urandom_range(0, 99) < 88) return client_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // fill_mode: mostly adds with a few ticks, to run the table full and
  // get rejected words; otherwise a mix of every command
  task automatic run_phase(input int count, input bit fill_mode);
    int pick;
    opcode_e op;
    refill_pool();
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (fill_mode) op = (pick < 92) ? OP_ADD : OP_TICK;
      else if (pick < 45) op = OP_ADD;
      else if (pick < 60) op = OP_DELETE;
      else if (pick < 92) op = OP_TICK;
      else op = OP_CLEAR;
      send_command(op, pick_client());
    end
  endtask

  initial begin
    logic [INTERVAL_W-1:0] interval;
    logic [TIMEOUT_W-1:0]  timeout;
    int                    waited;
    bit                    leftover;

    // reset once, released on a falling edge
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part at reset timing: empty scans, address extremes,
    // refresh of a present address, deletes of absent addresses, clear
    send_command(OP_TICK,   32'h0000_0000);
    send_command(OP_CLEAR,  32'hFFFF_FFFF);
    send_command(OP_ADD,    32'h0000_0000);
    send_command(OP_ADD,    32'hFFFF_FFFF);
    send_command(OP_ADD,    32'h0000_0000);
    send_command(OP_DELETE, 32'h1234_5678);
    send_command(OP_ADD,    32'h8000_0000);
    send_command(OP_ADD,    32'h7FFF_FFFF);
    send_command(OP_ADD,    32'h0000_0001);
    send_command(OP_TICK,   32'hFFFF_FFFF);
    send_command(OP_DELETE, 32'hFFFF_FFFF);
    send_command(OP_DELETE, 32'hFFFF_FFFF);
    send_command(OP_ADD,    32'hFFFF_FFFE);
    send_command(OP_CLEAR,  32'h0000_0000);
    send_command(OP_DELETE, 32'h0000_0000);
    send_command(OP_ADD,    32'hAAAA_AAAA);
    send_command(OP_ADD,    32'h5555_5555);

    // smallest interval, zero timeout: entries expire on their second tick,
    // a refresh in between holds one back
    program_timing(16'd1, 20'd0);
    send_command(OP_ADD,    32'h0000_0010);
    send_command(OP_ADD,    32'h0000_0030);
    send_command(OP_TICK,   32'h0);
    send_command(OP_ADD,    32'h0000_0030);
    send_command(OP_TICK,   32'h0);
    send_command(OP_TICK,   32'h0);

    // random phases over several timing settings
    program_timing(16'hFFFF, 20'd0);
    run_phase(36, 1'b0);

    // long stretch with no pauses at the widest timing
    sender_pauses = 1'b0;
    program_timing(16'hFFFF, 20'hFFFFF);
    run_phase(36, 1'b0);
    sender_pauses = 1'b1;

    interval = INTERVAL_W'($urandom_range(1, 65535));
    timeout  = TIMEOUT_W'($urandom_range(0,
                 (6 * interval > 1048575) ? 1048575 : 6 * interval));
    program_timing(interval, timeout);
    run_phase(36, 1'b0);

    // run the table full
    program_timing(16'd1, 20'hFFFFF);
    run_phase(45, 1'b1);

    interval = INTERVAL_W'($urandom_range(1, 65535));
    timeout  = TIMEOUT_W'($urandom_range(0,
                 (4 * interval > 1048575) ? 1048575 : 4 * interval));
    program_timing(interval, timeout);
    run_phase(36, 1'b0);

    program_timing(INTERVAL_RESET, TIMEOUT_RESET);
    run_phase(10, 1'b0);

    // drain: every expected word in, then a little extra for stray words
    @(negedge clk_i);
    start  = 1'b0;
    waited = 0;
    while (pending_count != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_WAIT) @(negedge clk_i);
    leftover = (pending_count != 0);
    if (leftover) $display("%0d expected event words never arrived", pending_count);

    if (error_count == 0 && !leftover) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- keepalive_aging_table.f -----
hw/rtl/kat_pkg.sv
hw/rtl/keepalive_aging_table.sv
verif/keepalive_event_checker.sv
verif/keepalive_aging_table_test.sv
